// File: hdl/pnle_pkg.sv
// shared types and constants for the parallel nibble link engine
// no dependencies; imported by every module of the block
package pnle_pkg;

  localparam int unsigned TIMER_BITS_DEF = 32;
  localparam logic [31:0] TIMEOUT_RST    = 32'd50000000;

  // configuration register indexes
  localparam logic REG_VARIANT = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SEND      = 2'd1,
    CMD_RECV      = 2'd2,
    CMD_WAIT_RECV = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       restart_timer;
    logic [7:0] status_lines;
  } in_t;

  typedef struct packed {
    logic [7:0] data_lines;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    logic       error_flag;
    logic       ready_res;
  } out_t;

  // item after classification in the front part
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       restart;
    logic [7:0] status;
    logic       busy;
    logic       start_seen;
  } front_item_t;

endpackage

// File: hdl/pnle_front.sv
// front part: accepts items, classifies them and holds them in a two-entry queue
// depends on pnle_pkg
module pnle_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  pnle_pkg::in_t        in_item_i,
  input  logic                 take_i,
  output logic                 avail_o,
  output pnle_pkg::front_item_t item_o
);
  import pnle_pkg::*;

  front_item_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;
  front_item_t cls;

  always_comb begin
    cls.cmd        = cmd_e'(in_item_i.opcode);
    cls.tx_byte    = in_item_i.tx_byte;
    cls.restart    = in_item_i.restart_timer;
    cls.status     = in_item_i.status_lines;
    cls.busy       = in_item_i.status_lines[7];
    // busy together with a nonzero nibble starts a wait-receive
    cls.start_seen = in_item_i.status_lines[7] && (in_item_i.status_lines[6:3] != 4'd0);
  end

  assign full    = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push && !full;
  assign do_pop  = take_i && avail_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hdl/pnle_engine.sv
// back part: handshake sequencer, timeout timer and configuration registers
// depends on pnle_pkg
module pnle_engine #(
  parameter int unsigned TIMER_BITS = pnle_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  pnle_pkg::front_item_t item_i,
  output pnle_pkg::out_t        result_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import pnle_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SP_W1   = 4'd1;
  localparam logic [3:0] PH_SP_LO   = 4'd2;
  localparam logic [3:0] PH_SP_W2   = 4'd3;
  localparam logic [3:0] PH_SP_HI   = 4'd4;
  localparam logic [3:0] PH_SC_W1   = 4'd5;
  localparam logic [3:0] PH_SC_B    = 4'd6;
  localparam logic [3:0] PH_SC_W2   = 4'd7;
  localparam logic [3:0] PH_SC_W3   = 4'd8;
  localparam logic [3:0] PH_R_W1    = 4'd9;
  localparam logic [3:0] PH_R_S1    = 4'd10;
  localparam logic [3:0] PH_R_W2    = 4'd11;
  localparam logic [3:0] PH_R_S2    = 4'd12;
  localparam logic [3:0] PH_W_START = 4'd13;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic                  variant_q;
  logic [31:0]           timeout_q;
  logic [TIMER_BITS-1:0] limit;

  logic [4:0]            phase_q, phase_d;
  logic [7:0]            work_q, work_d;
  logic [3:0]            low_q, low_d;
  logic [7:0]            drive_q, drive_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
  logic                  tout_q, tout_d;
  logic                  err_q, err_d;

  logic [3:0] ph;
  logic       wm;
  logic       frozen;
  logic       rx_v, done;
  logic [7:0] rx_b;
  logic [7:0] asm_byte;
  logic       sup;

  // effective limit: saturate to the timer range, zero acts as one
  always_comb begin
    if (64'(timeout_q) > 64'(TMAX)) begin
      limit = TMAX;
    end else begin
      limit = TIMER_BITS'(timeout_q);
    end
    if (limit == '0) begin
      limit = TIMER_BITS'(1);
    end
  end

  always_comb begin
    ph        = phase_q[3:0];
    wm        = phase_q[4];
    frozen    = (ph == PH_W_START);
    timer_inc = (timer_q != TMAX) ? timer_q + TIMER_BITS'(1) : timer_q;
    timer_d   = frozen ? timer_q : timer_inc;
    tout_d    = tout_q | (!frozen && (timer_inc >= limit));
    phase_d   = phase_q;
    work_d    = work_q;
    low_d     = low_q;
    drive_d   = drive_q;
    err_d     = err_q;
    rx_v      = 1'b0;
    rx_b      = 8'd0;
    done      = 1'b0;
    sup       = err_q;
    asm_byte  = {item_i.status[6:3], low_q};

    case (ph)
      PH_IDLE: begin
        case (item_i.cmd)
          CMD_SEND: begin
            if (sup) begin
              done = 1'b1;
            end else begin
              work_d  = item_i.tx_byte;
              timer_d = '0;
              tout_d  = 1'b0;
              phase_d = {1'b0, variant_q ? PH_SC_W1 : PH_SP_W1};
            end
          end
          CMD_RECV: begin
            if (sup) begin
              done = 1'b1;
            end else begin
              if (item_i.restart) begin
                timer_d = '0;
                tout_d  = 1'b0;
              end
              phase_d = {1'b0, PH_R_W1};
            end
          end
          CMD_WAIT_RECV: begin
            drive_d = drive_q & 8'hf7;
            phase_d = {1'b0, PH_W_START};
          end
          default: ;
        endcase
      end
      PH_SP_W1: begin
        if (item_i.busy || tout_d) begin
          drive_d = {4'h8, work_q[3:0]};
          phase_d = {1'b0, PH_SP_LO};
        end
      end
      PH_SP_LO: begin
        drive_d = drive_q & 8'h0f;
        phase_d = {1'b0, PH_SP_W2};
      end
      PH_SP_W2: begin
        if (!item_i.busy || tout_d) begin
          drive_d = {4'h8, work_q[7:4]};
          phase_d = {1'b0, PH_SP_HI};
        end
      end
      PH_SP_HI: begin
        drive_d = drive_q & 8'h0f;
        if (tout_d) begin
          err_d = 1'b1;
        end
        done    = 1'b1;
        phase_d = {1'b0, PH_IDLE};
      end
      PH_SC_W1: begin
        if (item_i.busy || tout_d) begin
          drive_d = work_q & 8'h07;
          phase_d = {1'b0, PH_SC_B};
        end
      end
      PH_SC_B: begin
        drive_d = drive_q | 8'h08;
        phase_d = {1'b0, PH_SC_W2};
      end
      PH_SC_W2: begin
        if (!item_i.busy || tout_d) begin
          drive_d = ({6'd0, work_q[4:3]} | (work_q & 8'h04)) ^ 8'h0d;
          phase_d = {1'b0, PH_SC_W3};
        end
      end
      PH_SC_W3: begin
        if (!item_i.status[3] || tout_d) begin
          drive_d = {5'd0, work_q[7:5] ^ 3'd3 ^ {2'd0, work_q[2]}};
          if (tout_d) begin
            err_d = 1'b1;
          end
          done    = 1'b1;
          phase_d = {1'b0, PH_IDLE};
        end
      end
      PH_R_W1: begin
        if (item_i.busy || tout_d) begin
          if (variant_q) begin
            low_d   = item_i.status[6:3];
            drive_d = 8'h08;
            phase_d = {wm, PH_R_W2};
          end else begin
            drive_d = 8'h80;
            phase_d = {wm, PH_R_S1};
          end
        end
      end
      PH_R_S1: begin
        low_d   = item_i.status[6:3];
        drive_d = 8'h00;
        phase_d = {wm, PH_R_W2};
      end
      PH_R_W2, PH_R_S2: begin
        if ((ph == PH_R_W2) && !(!item_i.busy || tout_d)) begin
          // still waiting for busy to drop
        end else if ((ph == PH_R_W2) && !variant_q) begin
          drive_d = 8'h80;
          phase_d = {wm, PH_R_S2};
        end else begin
          drive_d = 8'h00;
          work_d  = asm_byte;
          if (tout_d) begin
            err_d = 1'b1;
            if (wm) begin
              phase_d = {1'b0, PH_W_START};
            end else begin
              done    = 1'b1;
              phase_d = {1'b0, PH_IDLE};
            end
          end else begin
            rx_v    = 1'b1;
            rx_b    = asm_byte;
            done    = 1'b1;
            phase_d = {1'b0, PH_IDLE};
          end
        end
      end
      PH_W_START: begin
        if (item_i.start_seen) begin
          timer_d = '0;
          tout_d  = 1'b0;
          err_d   = 1'b0;
          phase_d = {1'b1, PH_R_W1};
        end
      end
      default: begin
        phase_d = {1'b0, PH_IDLE};
      end
    endcase
  end

  always_comb begin
    result_o.data_lines = drive_d;
    result_o.rx_byte    = rx_b;
    result_o.rx_valid   = rx_v;
    result_o.done_res   = done;
    result_o.error_flag = err_d;
    result_o.ready_res  = (phase_d == {1'b0, PH_IDLE});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
      timeout_q <= TIMEOUT_RST;
      phase_q   <= {1'b0, PH_IDLE};
      work_q    <= 8'd0;
      low_q     <= 4'd0;
      drive_q   <= 8'd0;
      timer_q   <= '0;
      tout_q    <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_VARIANT) begin
          variant_q <= cfg_data_i[0];
        end else begin
          timeout_q <= cfg_data_i;
        end
      end
      if (step_i) begin
        phase_q <= phase_d;
        work_q  <= work_d;
        low_q   <= low_d;
        drive_q <= drive_d;
        timer_q <= timer_d;
        tout_q  <= tout_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

// File: hdl/pnle_resq.sv
// result queue: two entries between the sequencer and the consumer
// depends on pnle_pkg
module pnle_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pnle_pkg::out_t wdata_i,
  output logic           room_o,
  output logic           empty,
  input  logic           pop,
  output pnle_pkg::out_t out_item_o
);
  import pnle_pkg::*;

  out_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign empty      = (count_q == 2'd0);
  assign room_o     = (count_q != 2'd2);
  assign out_item_o = mem_q[rd_ptr_q];
  assign do_pop     = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, wr_i} - {1'b0, do_pop};
    end
  end

endmodule

// File: hdl/parallel_nibble_link_engine_unit.sv
// top level of the parallel nibble link engine: front queue, sequencer, result queue
// depends on pnle_pkg, pnle_front, pnle_engine and pnle_resq
//
// Each pushed item is one clock tick of the link: it carries the sampled status
// lines and an optional command, and yields exactly one result item with the data
// lines, the received byte and the status flags after that tick. The sequencer
// takes one item per clock while one waits and the result queue has room; items
// go into the front queue, results into the result queue. Two-entry queues on
// both sides let the producer and the consumer stall independently. Configuration
// writes are always taken (ready stays high) and must be made while the block holds
// no unfinished item. The timeout counter is TIMER_BITS wide.
module parallel_nibble_link_engine_unit #(
  parameter int unsigned TIMER_BITS = pnle_pkg::TIMER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  pnle_pkg::in_t  in_item_i,
  output logic           empty,
  input  logic           pop,
  output pnle_pkg::out_t out_item_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import pnle_pkg::*;

  front_item_t item;
  logic        avail;
  logic        room;
  logic        step;
  out_t        result;

  assign cfg_ready_o = 1'b1;
  assign step        = avail && room;

  pnle_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .take_i    (step),
    .avail_o   (avail),
    .item_o    (item)
  );

  pnle_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .result_o    (result),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pnle_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (step),
    .wdata_i    (result),
    .room_o     (room),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
